// ===== rtl/core/bdq_pkg.sv =====
// ============================================================================
// bdq_pkg
// Shared types, constants and index helpers for the bounded deque with search.
// ============================================================================
`default_nettype none

package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_BACK  = 3'd3,
        OP_SEARCH    = 3'd4
    } op_t;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_SEARCH = 3'b100
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } store_ctrl_t;

    // base < DEPTH and off < DEPTH, so one conditional subtract wraps it
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == '0)
        begin
            r = IDX_W'(DEPTH - 1);
        end
        else
        begin
            r = idx - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bounded_deque_with_search_unit.sv =====
// ============================================================================
// bounded_deque_with_search_unit
// Bounded deque of signed values in a ring buffer, with linear key search.
// ============================================================================
// Usage:
//   Command channel: drive operation and value and raise start; the
//   transaction is taken at the clock edge where start is high and busy is
//   low. busy stays high until the result has been issued.
//   Result channel: done pulses for one cycle with status, position and
//   count valid in that cycle. The receiver cannot stall it.
//   Insert, delete and unknown codes are handled in the execute state, which
//   issues done; busy drops as done rises, so the next transaction can be
//   taken at the edge that ends the done cycle.
//   A search walks the stored entries one per cycle through the memory read
//   port and a single comparator. It ends at the first match, position p,
//   or after the last of the N entries held when the key is absent (with no
//   read on an empty list). The full depth is 16 entries.
//   Reset: front pointer and count clear to zero, sequencer goes idle; the
//   entry memory is not cleared, an entry is read only after it is written.
// ============================================================================
`default_nettype none

module bounded_deque_with_search_unit
    import bdq_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic        [OP_W-1:0]       operation,
    input  wire logic signed [DATA_WIDTH-1:0] value,
    output logic                              done,
    output logic             [ST_W-1:0]       status,
    output logic             [CNT_W-1:0]      position,
    output logic             [CNT_W-1:0]      count
);

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]      rd_pos_reg, rd_pos_next;
    logic                  done_reg, done_next;
    logic [ST_W-1:0]       status_reg, status_next;
    logic [CNT_W-1:0]      position_reg, position_next;

    store_ctrl_t           sctrl;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  is_full;
    logic                  is_empty;

    bdq_store u_store (
        .clk   (clk),
        .ctrl  (sctrl),
        .wdata (key_reg),
        .rdata (rdata)
    );

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        rd_valid_next = rd_valid_reg;
        rd_pos_next   = rd_pos_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        position_next = position_reg;
        sctrl         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = op_t'(operation);
                    key_next      = $unsigned(value);
                    scan_next     = '0;
                    rd_valid_next = 1'b0;
                    if (op_t'(operation) == OP_SEARCH)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                status_next   = ST_OK;
                position_next = '0;
                done_next     = 1'b1;
                state_next    = S_IDLE;
                case (op_reg)
                    OP_INS_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            front_next  = wrap_dec(front_reg);
                            sctrl.we    = 1'b1;
                            sctrl.waddr = wrap_dec(front_reg);
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    OP_INS_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            sctrl.we    = 1'b1;
                            sctrl.waddr = wrap_add(front_reg, count_reg);
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    OP_DEL_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            front_next = wrap_add(front_reg, CNT_W'(1));
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    OP_DEL_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_SEARCH:
            begin
                // read issued one cycle, compared the next
                if (rd_valid_reg && (rdata == key_reg))
                begin
                    status_next   = ST_OK;
                    position_next = rd_pos_reg;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if ((scan_reg == count_reg) && !rd_valid_reg)
                begin
                    status_next   = ST_OK;
                    position_next = '0;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (scan_reg < count_reg)
                begin
                    sctrl.re      = 1'b1;
                    sctrl.raddr   = wrap_add(front_reg, scan_reg);
                    scan_next     = scan_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                    rd_pos_next   = scan_reg + CNT_W'(1);
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        rd_pos_reg   <= rd_pos_next;
        status_reg   <= status_next;
        position_reg <= position_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign position = position_reg;
    assign count    = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE))
        else $error("result issued without work in progress");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (position_reg != '0)) |-> (position_reg <= count_reg))
        else $error("search position beyond held entries");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_FULL)) |-> is_full)
        else $error("full status with room left");

endmodule

`default_nettype wire

// ===== rtl/core/bdq_store.sv =====
// ============================================================================
// bdq_store
// Entry memory: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module bdq_store
    import bdq_pkg::*;
(
    input  wire logic                  clk,
    input  wire store_ctrl_t           ctrl,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[ctrl.waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.re)
        begin
            rdata_reg <= mem[ctrl.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
